### rtl/dda_line_rasterizer_unit_assert.svh
// assertion macros shared by the rasterizer checker
// no dependencies; included by files that assert
`ifndef DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define DDA_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define DDA_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("dda assertion failed");

// next-cycle implication
`define DDA_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("dda assertion failed");

`endif

### rtl/dda_pkg.sv
// shared types and constants of the dda line rasterizer
// no dependencies; imported by every rasterizer module
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

   // default geometry
   localparam int DDA_COORD_BITS  = 12;
   localparam int DDA_FRAC_BITS   = 16;
   // depth of the queue between front and back (power of two)
   localparam int DDA_QUEUE_DEPTH = 2;

   // item command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // classification of one queued item
   typedef struct packed {
      logic is_load;
      logic neg_x;
      logic neg_y;
   } dda_ctrl_type;

   // back end sequencer
   typedef enum logic {
      BACK_RUN,
      BACK_DIV
   } dda_back_state_type;

endpackage

`default_nettype wire

### rtl/dda_line_rasterizer_unit.sv
// DDA line rasterizer. A load item (cmd 0) latches two endpoints and
// computes signed Q1.FRAC_BITS per-step increments by a two-lane bit-serial
// divider; it emits nothing. Each step item (cmd 1) emits the current
// position rounded half up and advances; a line of n steps gives n+1 pixels,
// the last flagged by rsp_last_pixel, and a step with no line gives nothing.
// Step items sustain one pixel per cycle through the output register while
// rsp_ready keeps it free. A load occupies the back end while the divider
// produces one quotient bit per cycle; a two-entry queue in front keeps
// accepting items meanwhile until it is full.
// Top level; depends on dda_pkg, dda_front, dda_back and dda_div.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer_unit import dda_pkg::*; #(
   parameter int COORD_BITS = DDA_COORD_BITS,
   parameter int FRAC_BITS  = DDA_FRAC_BITS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire                      req_cmd,
   input  wire  [COORD_BITS-1:0]    req_start_x,
   input  wire  [COORD_BITS-1:0]    req_start_y,
   input  wire  [COORD_BITS-1:0]    req_end_x,
   input  wire  [COORD_BITS-1:0]    req_end_y,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_pixel_x,
   output logic [COORD_BITS-1:0]    rsp_pixel_y,
   output logic                     rsp_last_pixel
);

   logic                  q_valid;
   dda_ctrl_type          q_ctrl;
   logic [COORD_BITS-1:0] q_x0;
   logic [COORD_BITS-1:0] q_y0;
   logic [COORD_BITS-1:0] q_adx;
   logic [COORD_BITS-1:0] q_ady;
   logic [COORD_BITS-1:0] q_steps;
   logic                  q_pop;

   // accept and classify
   dda_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .q_valid     (q_valid),
      .q_ctrl      (q_ctrl),
      .q_x0        (q_x0),
      .q_y0        (q_y0),
      .q_adx       (q_adx),
      .q_ady       (q_ady),
      .q_steps     (q_steps),
      .q_pop       (q_pop)
   );

   // divide and step
   dda_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ctrl         (q_ctrl),
      .q_x0           (q_x0),
      .q_y0           (q_y0),
      .q_adx          (q_adx),
      .q_ady          (q_ady),
      .q_steps        (q_steps),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

`default_nettype wire

### rtl/dda_front.sv
// front end: accepts items, classifies them and holds them in a short queue
// depends on dda_pkg
`timescale 1ns / 1ps
`default_nettype none

module dda_front import dda_pkg::*; #(
   parameter int COORD_BITS = DDA_COORD_BITS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire                      req_cmd,
   input  wire  [COORD_BITS-1:0]    req_start_x,
   input  wire  [COORD_BITS-1:0]    req_start_y,
   input  wire  [COORD_BITS-1:0]    req_end_x,
   input  wire  [COORD_BITS-1:0]    req_end_y,
   output logic                     q_valid,
   output dda_ctrl_type             q_ctrl,
   output logic [COORD_BITS-1:0]    q_x0,
   output logic [COORD_BITS-1:0]    q_y0,
   output logic [COORD_BITS-1:0]    q_adx,
   output logic [COORD_BITS-1:0]    q_ady,
   output logic [COORD_BITS-1:0]    q_steps,
   input  wire                      q_pop
);

   localparam int PTR_BITS = (DDA_QUEUE_DEPTH > 1) ? $clog2(DDA_QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DDA_QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DDA_QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DDA_QUEUE_DEPTH);

   dda_ctrl_type          ctrl_ff  [DDA_QUEUE_DEPTH];
   logic [COORD_BITS-1:0] x0_ff    [DDA_QUEUE_DEPTH];
   logic [COORD_BITS-1:0] y0_ff    [DDA_QUEUE_DEPTH];
   logic [COORD_BITS-1:0] adx_ff   [DDA_QUEUE_DEPTH];
   logic [COORD_BITS-1:0] ady_ff   [DDA_QUEUE_DEPTH];
   logic [COORD_BITS-1:0] steps_ff [DDA_QUEUE_DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   dda_ctrl_type          entry_ctrl_in;
   logic [COORD_BITS-1:0] entry_adx_in;
   logic [COORD_BITS-1:0] entry_ady_in;
   logic [COORD_BITS-1:0] entry_steps_in;
   logic                  push;

   // classify: load direction, span per axis and step count
   always_comb begin
      entry_ctrl_in.is_load = (req_cmd == CMD_LOAD);
      entry_ctrl_in.neg_x   = (req_end_x < req_start_x);
      entry_ctrl_in.neg_y   = (req_end_y < req_start_y);
      entry_adx_in   = entry_ctrl_in.neg_x ? (req_start_x - req_end_x)
                                           : (req_end_x - req_start_x);
      entry_ady_in   = entry_ctrl_in.neg_y ? (req_start_y - req_end_y)
                                           : (req_end_y - req_start_y);
      entry_steps_in = (entry_adx_in > entry_ady_in) ? entry_adx_in : entry_ady_in;
   end

   // queue pointers and fill count
   always_comb begin
      req_ready = (count_ff != CNT_FULL);
      push      = req_valid && req_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ptr_ff]  <= entry_ctrl_in;
         x0_ff[wr_ptr_ff]    <= req_start_x;
         y0_ff[wr_ptr_ff]    <= req_start_y;
         adx_ff[wr_ptr_ff]   <= entry_adx_in;
         ady_ff[wr_ptr_ff]   <= entry_ady_in;
         steps_ff[wr_ptr_ff] <= entry_steps_in;
      end
   end

   // head of queue
   assign q_valid = (count_ff != '0);
   assign q_ctrl  = ctrl_ff[rd_ptr_ff];
   assign q_x0    = x0_ff[rd_ptr_ff];
   assign q_y0    = y0_ff[rd_ptr_ff];
   assign q_adx   = adx_ff[rd_ptr_ff];
   assign q_ady   = ady_ff[rd_ptr_ff];
   assign q_steps = steps_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### rtl/dda_div.sv
// two-lane restoring divider, one quotient bit per cycle per lane
// depends on dda_pkg
`timescale 1ns / 1ps
`default_nettype none

module dda_div import dda_pkg::*; #(
   parameter int COORD_BITS = DDA_COORD_BITS,
   parameter int FRAC_BITS  = DDA_FRAC_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire  [COORD_BITS-1:0]  dividend_x,
   input  wire  [COORD_BITS-1:0]  dividend_y,
   input  wire  [COORD_BITS-1:0]  divisor,
   output logic                   done,
   output logic [FRAC_BITS:0]     quot_x,
   output logic [FRAC_BITS:0]     quot_y
);

   // quotient carries one integer bit and FRAC_BITS fraction bits
   localparam int QUOT_BITS = FRAC_BITS + 1;
   localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] divisor_ff, divisor_in;
   logic [COORD_BITS:0]   rem_x_ff, rem_x_in;
   logic [COORD_BITS:0]   rem_y_ff, rem_y_in;
   logic [QUOT_BITS-1:0]  quot_x_ff, quot_x_in;
   logic [QUOT_BITS-1:0]  quot_y_ff, quot_y_in;

   logic                  ge_x, ge_y;
   logic [COORD_BITS:0]   diff_x, diff_y;

   // one trial subtract per lane; the remainder stays below the divisor
   always_comb begin
      ge_x   = (rem_x_ff >= {1'b0, divisor_ff});
      ge_y   = (rem_y_ff >= {1'b0, divisor_ff});
      diff_x = ge_x ? (rem_x_ff - {1'b0, divisor_ff}) : rem_x_ff;
      diff_y = ge_y ? (rem_y_ff - {1'b0, divisor_ff}) : rem_y_ff;

      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      quot_x_in  = quot_x_ff;
      quot_y_in  = quot_y_ff;

      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_BITS'(QUOT_BITS);
         divisor_in = divisor;
         rem_x_in   = {1'b0, dividend_x};
         rem_y_in   = {1'b0, dividend_y};
         quot_x_in  = '0;
         quot_y_in  = '0;
      end else if (busy_ff) begin
         rem_x_in  = {diff_x[COORD_BITS-1:0], 1'b0};
         rem_y_in  = {diff_y[COORD_BITS-1:0], 1'b0};
         quot_x_in = {quot_x_ff[QUOT_BITS-2:0], ge_x};
         quot_y_in = {quot_y_ff[QUOT_BITS-2:0], ge_y};
         cnt_in    = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      quot_x_ff  <= quot_x_in;
      quot_y_ff  <= quot_y_in;
   end

   assign done   = done_ff;
   assign quot_x = quot_x_ff;
   assign quot_y = quot_y_ff;

endmodule

`default_nettype wire

### rtl/dda_back.sv
// back end: runs loads through the divider and steps the accumulators
// depends on dda_pkg and dda_div
`timescale 1ns / 1ps
`default_nettype none

module dda_back import dda_pkg::*; #(
   parameter int COORD_BITS = DDA_COORD_BITS,
   parameter int FRAC_BITS  = DDA_FRAC_BITS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      q_valid,
   input  dda_ctrl_type             q_ctrl,
   input  wire  [COORD_BITS-1:0]    q_x0,
   input  wire  [COORD_BITS-1:0]    q_y0,
   input  wire  [COORD_BITS-1:0]    q_adx,
   input  wire  [COORD_BITS-1:0]    q_ady,
   input  wire  [COORD_BITS-1:0]    q_steps,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_pixel_x,
   output logic [COORD_BITS-1:0]    rsp_pixel_y,
   output logic                     rsp_last_pixel
);

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS;
   localparam int INC_BITS  = FRAC_BITS + 2;
   localparam int LEFT_BITS = COORD_BITS + 1;
   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   dda_back_state_type    state_ff, state_in;
   logic [ACC_BITS-1:0]   acc_x_ff, acc_x_in;
   logic [ACC_BITS-1:0]   acc_y_ff, acc_y_in;
   logic [INC_BITS-1:0]   inc_x_ff, inc_x_in;
   logic [INC_BITS-1:0]   inc_y_ff, inc_y_in;
   logic [LEFT_BITS-1:0]  left_ff, left_in;
   dda_ctrl_type          ctrl_ff, ctrl_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in;
   logic [COORD_BITS-1:0] start_y_ff, start_y_in;
   logic [COORD_BITS-1:0] steps_ff, steps_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0] pixel_y_ff, pixel_y_in;
   logic                  last_ff, last_in;

   logic                  div_start;
   logic                  div_done;
   logic [FRAC_BITS:0]    div_quot_x;
   logic [FRAC_BITS:0]    div_quot_y;
   logic [ACC_BITS-1:0]   round_x, round_y;
   logic [ACC_BITS-1:0]   inc_ext_x, inc_ext_y;
   logic                  out_free;

   dda_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (q_adx),
      .dividend_y (q_ady),
      .divisor    (q_steps),
      .done       (div_done),
      .quot_x     (div_quot_x),
      .quot_y     (div_quot_y)
   );

   // rounded position and sign-extended increments
   always_comb begin
      round_x   = acc_x_ff + ROUND_HALF;
      round_y   = acc_y_ff + ROUND_HALF;
      inc_ext_x = {{(ACC_BITS - INC_BITS){inc_x_ff[INC_BITS-1]}}, inc_x_ff};
      inc_ext_y = {{(ACC_BITS - INC_BITS){inc_y_ff[INC_BITS-1]}}, inc_y_ff};
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // sequencer: take queued items, divide on load, emit on step, drop a step with no line
   always_comb begin
      state_in     = state_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      inc_x_in     = inc_x_ff;
      inc_y_in     = inc_y_ff;
      left_in      = left_ff;
      ctrl_in      = ctrl_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      steps_in     = steps_ff;
      pixel_x_in   = pixel_x_ff;
      pixel_y_in   = pixel_y_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         BACK_RUN: begin
            if (q_valid) begin
               if (q_ctrl.is_load) begin
                  q_pop      = 1'b1;
                  div_start  = 1'b1;
                  ctrl_in    = q_ctrl;
                  start_x_in = q_x0;
                  start_y_in = q_y0;
                  steps_in   = q_steps;
                  state_in   = BACK_DIV;
               end else if (left_ff == '0) begin
                  // step with no line in progress: dropped
                  q_pop = 1'b1;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  rsp_valid_in = 1'b1;
                  pixel_x_in   = round_x[ACC_BITS-1:FRAC_BITS];
                  pixel_y_in   = round_y[ACC_BITS-1:FRAC_BITS];
                  last_in      = (left_ff == LEFT_BITS'(1));
                  acc_x_in     = acc_x_ff + inc_ext_x;
                  acc_y_in     = acc_y_ff + inc_ext_y;
                  left_in      = left_ff - LEFT_BITS'(1);
               end
            end
         end
         BACK_DIV: begin
            if (div_done) begin
               if (steps_ff == '0) begin
                  // zero-length line: no motion, one pixel
                  inc_x_in = '0;
                  inc_y_in = '0;
               end else begin
                  inc_x_in = ctrl_ff.neg_x ? (INC_BITS'(0) - {1'b0, div_quot_x})
                                           : {1'b0, div_quot_x};
                  inc_y_in = ctrl_ff.neg_y ? (INC_BITS'(0) - {1'b0, div_quot_y})
                                           : {1'b0, div_quot_y};
               end
               acc_x_in = {start_x_ff, FRAC_BITS'(0)};
               acc_y_in = {start_y_ff, FRAC_BITS'(0)};
               left_in  = LEFT_BITS'(steps_ff) + LEFT_BITS'(1);
               state_in = BACK_RUN;
            end
         end
         default: state_in = BACK_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_RUN;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         inc_x_ff     <= '0;
         inc_y_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         inc_x_ff     <= inc_x_in;
         inc_y_ff     <= inc_y_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff    <= ctrl_in;
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      steps_ff   <= steps_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = pixel_x_ff;
   assign rsp_pixel_y    = pixel_y_ff;
   assign rsp_last_pixel = last_ff;

endmodule

`default_nettype wire

### rtl/dda_chk.sv
// port-level checks of the rasterizer, bound to the top level
// depends on dda_pkg and dda_line_rasterizer_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "dda_line_rasterizer_unit_assert.svh"

module dda_chk import dda_pkg::*; #(
   parameter int COORD_BITS = DDA_COORD_BITS
) (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_ready,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire [COORD_BITS-1:0]  rsp_pixel_x,
   input wire [COORD_BITS-1:0]  rsp_pixel_y,
   input wire                   rsp_last_pixel
);

   // result stall and the result payload as one vector
   logic                  rsp_stall;
   logic [2*COORD_BITS:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_pixel_x, rsp_pixel_y, rsp_last_pixel};

   // a stalled result item holds
   `DDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // reset leaves the queue empty
   `DDA_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_ready)

   // no pixel can come out right after reset: a load must divide first
   `DDA_ASSERT_IMPLY(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind dda_line_rasterizer_unit dda_chk #(
   .COORD_BITS (COORD_BITS)
) u_dda_chk (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pixel_x    (rsp_pixel_x),
   .rsp_pixel_y    (rsp_pixel_y),
   .rsp_last_pixel (rsp_last_pixel)
);

`default_nettype wire
